// ===== design/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication checked on every rising edge outside reset
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrs assertion failed");

// a stalled result keeps its valid and its payload
`define QRS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("qrs stalled item changed");

`endif

// ===== design/qrs_pkg.sv =====
// shared types and constants of the quadratic root solver
// no dependencies
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int RES_BITS = 32;

    typedef enum logic [1:0] {
        KIND_DISTINCT   = 2'd0,
        KIND_DOUBLE     = 2'd1,
        KIND_COMPLEX    = 2'd2,
        KIND_DEGENERATE = 2'd3
    } kind_t;

    localparam logic [RES_BITS-1:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [RES_BITS-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// ===== design/qrs_in_if.sv =====
// coefficient channel: valid, ready and one set of coefficients
// depends on nothing
`timescale 1ns / 1ps

interface qrs_in_if #(
    parameter int COEF_BITS = 16
) ();
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ===== design/qrs_out_if.sv =====
// result channel: valid, ready, root kind, roots, vertex and clip flag
// depends on qrs_pkg
`timescale 1ns / 1ps

interface qrs_out_if ();
    logic                                  valid;
    logic                                  ready;
    qrs_pkg::kind_t                        root_kind;
    logic signed [qrs_pkg::RES_BITS-1:0]   root_one;
    logic signed [qrs_pkg::RES_BITS-1:0]   root_two;
    logic signed [qrs_pkg::RES_BITS-1:0]   vertex_x;
    logic signed [qrs_pkg::RES_BITS-1:0]   vertex_y;
    logic                                  saturated;

    modport source (output valid, output root_kind, output root_one, output root_two,
                    output vertex_x, output vertex_y, output saturated, input ready);
    modport sink   (input valid, input root_kind, input root_one, input root_two,
                    input vertex_x, input vertex_y, input saturated, output ready);
endinterface

// ===== design/qrs_div.sv =====
// pipelined restoring divider: 32-bit quotient of num/den plus overflow flag
// depends on qrs_pkg; one division per cycle while en is high
`timescale 1ns / 1ps

module qrs_div #(
    parameter int NW = 80,
    parameter int DW = 18
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NW-1:0]                 num,
    input  logic [DW-1:0]                 den,
    output logic [qrs_pkg::RES_BITS-1:0]  quo,
    output logic                          ovf
);

    localparam int QB = qrs_pkg::RES_BITS;

    logic [NW-QB-1:0] num_hi;
    logic             hi_ge;

    logic [DW-1:0] rem_reg [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] lo_reg  [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];

    assign num_hi = num[NW-1:QB];
    // quotient needs more than QB bits when the upper part already reaches den
    assign hi_ge  = (num_hi >= (NW-QB)'(den));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= hi_ge;
            rem_reg[0] <= hi_ge ? '0 : DW'(num_hi);
            den_reg[0] <= den;
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW:0]   rem_sub;

        assign rem_sh  = {rem_reg[k], lo_reg[k][QB-1]};
        assign ge      = (rem_sh >= {1'b0, den_reg[k]});
        assign rem_sub = rem_sh - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QB-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                    den_reg[k+1] <= den_reg[k];
                    lo_reg[k+1]  <= {lo_reg[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

// ===== design/quadratic_root_solver_top.sv =====
// Quadratic root solver: one coefficient set (a, b, c) in, one result out, fully pipelined.
// A new item is taken every cycle unless the result channel stalls; the result passes
// the square root pipeline (one result bit per stage, 32 + FRAC_BITS stages) and the
// divider pipelines (33 stages). When the result channel stalls the whole pipe holds.
// Results are signed Q(32-FRAC_BITS).FRAC_BITS, clipped to 32 bits with the saturated
// flag; a zero leading coefficient gives the degenerate kind with all other fields
// zero.
// depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_div
`timescale 1ns / 1ps

module quadratic_root_solver_top #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    qrs_in_if.sink    req,
    qrs_out_if.source rsp
);

    localparam int RB        = qrs_pkg::RES_BITS;
    localparam int DW        = COEF_BITS + 2;
    localparam int RTW       = 32 + FRAC_BITS;
    localparam int RMW       = RTW + 2;
    localparam int SQ_STAGES = 32 + FRAC_BITS;
    localparam int NW        = 64 + FRAC_BITS;
    localparam int NSW       = NW + 1;
    localparam int DIV_LAT   = RB + 1;

    typedef struct packed {
        logic                        deg;
        logic                        a_neg;
        logic                        d_pos;
        logic                        d_neg;
        logic                        vx_neg;
        logic                        vy_neg;
        logic signed [COEF_BITS-1:0] b;
        logic [COEF_BITS-1:0]        abs_b;
        logic [COEF_BITS-1:0]        ua;
        logic [63:0]                 dmag;
    } side_t;

    typedef struct packed {
        qrs_pkg::kind_t kind;
        logic           vx_neg;
        logic           vy_neg;
        logic           p_neg;
        logic           m_neg;
    } tail_t;

    function automatic logic [RB:0] fix_res(logic neg, logic ovf, logic [RB-1:0] q);
        logic [RB-1:0] v;
        logic          s;
        if (ovf)
        begin
            s = 1'b1;
            v = neg ? qrs_pkg::SAT_NEG : qrs_pkg::SAT_POS;
        end
        else if (neg)
        begin
            s = (q > qrs_pkg::SAT_NEG);
            v = s ? qrs_pkg::SAT_NEG : -q;
        end
        else
        begin
            s = (q > qrs_pkg::SAT_POS);
            v = s ? qrs_pkg::SAT_POS : q;
        end
        return {s, v};
    endfunction

    logic en;
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    // input and product stages
    logic                        v0_reg, v1_reg, v2_reg;
    logic signed [COEF_BITS-1:0] a0_reg, b0_reg, c0_reg;
    logic signed [COEF_BITS-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [63:0]          bb1_reg, ac1_reg, d2_reg;
    logic signed [2*COEF_BITS-1:0] bb_prod, ac_prod;

    assign bb_prod = b0_reg * b0_reg;
    assign ac_prod = a0_reg * c0_reg;

    // discriminant flags and magnitudes entering the root pipe
    side_t side_next;
    logic  b_neg2;

    always_comb
    begin
        b_neg2           = b2_reg[COEF_BITS-1];
        side_next.deg    = (a2_reg == '0);
        side_next.a_neg  = a2_reg[COEF_BITS-1];
        side_next.d_neg  = d2_reg[63];
        side_next.d_pos  = !d2_reg[63] && (d2_reg != '0);
        side_next.vx_neg = (b_neg2 == a2_reg[COEF_BITS-1]);
        side_next.vy_neg = (side_next.d_pos && !side_next.a_neg)
                        || (side_next.d_neg && side_next.a_neg);
        side_next.b      = b2_reg;
        side_next.abs_b  = b_neg2 ? $unsigned(-b2_reg) : $unsigned(b2_reg);
        side_next.ua     = side_next.a_neg ? $unsigned(-a2_reg) : $unsigned(a2_reg);
        side_next.dmag   = d2_reg[63] ? $unsigned(-d2_reg) : $unsigned(d2_reg);
    end

    // square root pipe, one result bit per stage
    logic           sq_v_reg    [0:SQ_STAGES];
    side_t          sq_side_reg [0:SQ_STAGES];
    logic [RTW-1:0] sq_root_reg [0:SQ_STAGES];
    logic [RMW-1:0] sq_rem_reg  [0:SQ_STAGES-1];
    logic [63:0]    sq_mag_reg  [0:SQ_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg      <= req.valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            sq_v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg         <= req.coef_a;
            b0_reg         <= req.coef_b;
            c0_reg         <= req.coef_c;
            bb1_reg        <= 64'(bb_prod);
            ac1_reg        <= 64'(ac_prod);
            a1_reg         <= a0_reg;
            b1_reg         <= b0_reg;
            d2_reg         <= bb1_reg - (ac1_reg <<< 2);
            a2_reg         <= a1_reg;
            b2_reg         <= b1_reg;
            sq_side_reg[0] <= side_next;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_mag_reg[0]  <= side_next.dmag;
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        // bring down the next pair of bits; pairs run out to zero after 32 stages
        assign rem_sh = {sq_rem_reg[k][RMW-3:0], sq_mag_reg[k][63:62]};
        assign trial  = {sq_root_reg[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][RTW-2:0], ge};
            end
        end

        if (k < SQ_STAGES-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[k+1] <= ge ? (rem_sh - trial) : rem_sh;
                    sq_mag_reg[k+1] <= {sq_mag_reg[k][61:0], 2'b00};
                end
            end
        end
    end

    // numerators of the real roots
    side_t           sd_s;
    logic [RTW-1:0]  root_s;
    logic signed [NSW-1:0] nb, n1_next, n2_next;

    assign sd_s    = sq_side_reg[SQ_STAGES];
    assign root_s  = sq_root_reg[SQ_STAGES];
    assign nb      = -(NSW'(sd_s.b)) <<< FRAC_BITS;
    assign n1_next = nb + $signed(NSW'(root_s));
    assign n2_next = nb - $signed(NSW'(root_s));

    logic                  nv1_reg;
    side_t                 ns1_reg;
    logic [RTW-1:0]        nr1_reg;
    logic signed [NSW-1:0] n1_reg, n2_reg;

    // divider operands
    logic                  tv_reg [0:DIV_LAT];
    tail_t                 tl_reg [0:DIV_LAT];
    tail_t                 tail_next;
    logic [NW-1:0]         num_vx_reg, num_vy_reg, num_p_reg, num_m_reg;
    logic [DW-1:0]         den2_reg, den4_reg;
    logic signed [NSW-1:0] n1_mag, n2_mag;

    assign n1_mag = n1_reg[NSW-1] ? -n1_reg : n1_reg;
    assign n2_mag = n2_reg[NSW-1] ? -n2_reg : n2_reg;

    always_comb
    begin
        if (ns1_reg.deg)
        begin
            tail_next.kind = qrs_pkg::KIND_DEGENERATE;
        end
        else if (ns1_reg.d_pos)
        begin
            tail_next.kind = qrs_pkg::KIND_DISTINCT;
        end
        else if (ns1_reg.d_neg)
        begin
            tail_next.kind = qrs_pkg::KIND_COMPLEX;
        end
        else
        begin
            tail_next.kind = qrs_pkg::KIND_DOUBLE;
        end
        tail_next.vx_neg = ns1_reg.vx_neg;
        tail_next.vy_neg = ns1_reg.vy_neg;
        tail_next.p_neg  = ns1_reg.d_neg ? ns1_reg.a_neg : (n1_reg[NSW-1] != ns1_reg.a_neg);
        tail_next.m_neg  = (n2_reg[NSW-1] != ns1_reg.a_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv1_reg   <= 1'b0;
            tv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            nv1_reg   <= sq_v_reg[SQ_STAGES];
            tv_reg[0] <= nv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns1_reg    <= sd_s;
            nr1_reg    <= root_s;
            n1_reg     <= n1_next;
            n2_reg     <= n2_next;
            tl_reg[0]  <= tail_next;
            num_vx_reg <= NW'(ns1_reg.abs_b) << FRAC_BITS;
            num_vy_reg <= NW'(ns1_reg.dmag) << FRAC_BITS;
            // the imaginary part divides the bare root
            num_p_reg  <= ns1_reg.d_neg ? NW'(nr1_reg) : NW'(n1_mag);
            num_m_reg  <= NW'(n2_mag);
            den2_reg   <= DW'(ns1_reg.ua) << 1;
            den4_reg   <= DW'(ns1_reg.ua) << 2;
        end
    end

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_tail
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                tv_reg[k+1] <= tv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tl_reg[k+1] <= tl_reg[k];
            end
        end
    end

    logic [RB-1:0] q_vx, q_vy, q_p, q_m;
    logic          o_vx, o_vy, o_p, o_m;

    qrs_div #(.NW(NW), .DW(DW)) u_div_vx (
        .clk(clk), .en(en), .num(num_vx_reg), .den(den2_reg), .quo(q_vx), .ovf(o_vx)
    );
    qrs_div #(.NW(NW), .DW(DW)) u_div_vy (
        .clk(clk), .en(en), .num(num_vy_reg), .den(den4_reg), .quo(q_vy), .ovf(o_vy)
    );
    qrs_div #(.NW(NW), .DW(DW)) u_div_p (
        .clk(clk), .en(en), .num(num_p_reg), .den(den2_reg), .quo(q_p), .ovf(o_p)
    );
    qrs_div #(.NW(NW), .DW(DW)) u_div_m (
        .clk(clk), .en(en), .num(num_m_reg), .den(den2_reg), .quo(q_m), .ovf(o_m)
    );

    // clip, sign and select
    tail_t          tl_s;
    logic [RB:0]    f_vx, f_vy, f_p, f_m;
    qrs_pkg::kind_t kind_next;
    logic [RB-1:0]  r1_next, r2_next, vx_next, vy_next;
    logic           sat_next;

    assign tl_s = tl_reg[DIV_LAT];
    assign f_vx = fix_res(tl_s.vx_neg, o_vx, q_vx);
    assign f_vy = fix_res(tl_s.vy_neg, o_vy, q_vy);
    assign f_p  = fix_res(tl_s.p_neg, o_p, q_p);
    assign f_m  = fix_res(tl_s.m_neg, o_m, q_m);

    always_comb
    begin
        kind_next = tl_s.kind;
        vx_next   = f_vx[RB-1:0];
        vy_next   = f_vy[RB-1:0];
        r1_next   = f_vx[RB-1:0];
        r2_next   = f_vx[RB-1:0];
        sat_next  = f_vx[RB] | f_vy[RB];
        case (tl_s.kind)
            qrs_pkg::KIND_DISTINCT:
            begin
                r1_next  = f_p[RB-1:0];
                r2_next  = f_m[RB-1:0];
                sat_next = f_vx[RB] | f_vy[RB] | f_p[RB] | f_m[RB];
            end
            qrs_pkg::KIND_COMPLEX:
            begin
                r2_next  = f_p[RB-1:0];
                sat_next = f_vx[RB] | f_vy[RB] | f_p[RB];
            end
            qrs_pkg::KIND_DEGENERATE:
            begin
                vx_next  = '0;
                vy_next  = '0;
                r1_next  = '0;
                r2_next  = '0;
                sat_next = 1'b0;
            end
            default:
            begin
                sat_next = f_vx[RB] | f_vy[RB];
            end
        endcase
    end

    logic           out_valid_reg;
    qrs_pkg::kind_t kind_reg;
    logic [RB-1:0]  r1_reg, r2_reg, vx_reg, vy_reg;
    logic           sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tv_reg[DIV_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= kind_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            sat_reg  <= sat_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.root_kind = kind_reg;
    assign rsp.root_one  = $signed(r1_reg);
    assign rsp.root_two  = $signed(r2_reg);
    assign rsp.vertex_x  = $signed(vx_reg);
    assign rsp.vertex_y  = $signed(vy_reg);
    assign rsp.saturated = sat_reg;

endmodule

// ===== design/qrs_checker.sv =====
// port-level checks on the result channel of the root solver, bound to the top level
// depends on qrs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qrs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   root_kind,
    input logic [qrs_pkg::RES_BITS-1:0] root_one,
    input logic [qrs_pkg::RES_BITS-1:0] root_two,
    input logic [qrs_pkg::RES_BITS-1:0] vertex_x,
    input logic [qrs_pkg::RES_BITS-1:0] vertex_y,
    input logic                         saturated
);

    logic [4*qrs_pkg::RES_BITS+2:0] out_bits;
    logic                           is_degen, is_double, is_complex;
    logic                           degen_blank, double_ok, complex_ok;

    assign out_bits    = {root_kind, root_one, root_two, vertex_x, vertex_y, saturated};
    assign is_degen    = out_valid && (root_kind == qrs_pkg::KIND_DEGENERATE);
    assign is_double   = out_valid && (root_kind == qrs_pkg::KIND_DOUBLE);
    assign is_complex  = out_valid && (root_kind == qrs_pkg::KIND_COMPLEX);
    assign degen_blank = (root_one == '0) && (root_two == '0) && (vertex_x == '0)
                      && (vertex_y == '0) && !saturated;
    assign double_ok   = (root_one == vertex_x) && (root_two == vertex_x);
    assign complex_ok  = (root_one == vertex_x);

    `QRS_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_bits)

    // a zero leading coefficient blanks every other field
    `QRS_ASSERT(a_degen_zero, clk, rst_n, is_degen |-> degen_blank)

    `QRS_ASSERT(a_double_vertex, clk, rst_n, is_double |-> double_ok)

    // real part of a complex pair is the vertex abscissa
    `QRS_ASSERT(a_complex_real, clk, rst_n, is_complex |-> complex_ok)

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .root_kind (rsp.root_kind),
    .root_one  (rsp.root_one),
    .root_two  (rsp.root_two),
    .vertex_x  (rsp.vertex_x),
    .vertex_y  (rsp.vertex_y),
    .saturated (rsp.saturated)
);

// ===== tb/tb.sv =====
// testbench for quadratic_root_solver_top: coefficient sets in, roots and vertex checked out
// depends on qrs_pkg, qrs_in_if, qrs_out_if and the solver rtl
`timescale 1ns / 1ps

module tb;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = FB + 71;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
    } coef_t;

    typedef struct packed {
        qrs_pkg::kind_t     kind;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sat;
    } solution_t;

    logic clk;
    logic rst_n;

    qrs_in_if #(.COEF_BITS(CB)) req ();
    qrs_out_if rsp ();

    quadratic_root_solver_top #(.COEF_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    coef_t     coef_queue[$];
    solution_t solution_queue[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off_req;
    bit        hold_off_done;
    int        hold_off_cycles;
    int        errors;
    int        quiet_cycles;
    bit        in_fire;

    // floor(sqrt(mag) * 2^FB), one bit per step
    function automatic logic [63:0] root_scaled(logic [63:0] mag);
        logic [65:0] rem;
        logic [65:0] trial;
        logic [63:0] root;
        rem  = '0;
        root = '0;
        for (int i = 0; i < 32 + FB; i++)
        begin
            rem   = {rem[63:0], (i < 32) ? mag[63-2*i -: 2] : 2'b00};
            trial = {root, 2'b01};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end
            else
                root = {root[62:0], 1'b0};
        end
        return root;
    endfunction

    // trunc(+-num * 2^sh / den), clipped to 32 bits signed
    function automatic logic signed [31:0] scaled_div(bit neg, logic [63:0] num,
                                                      logic [63:0] den, int sh,
                                                      inout bit sat);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        q = num / den;
        r = num % den;
        if ((q >> (32 - sh)) != 0)
        begin
            sat = 1;
            return neg ? qrs_pkg::SAT_NEG : qrs_pkg::SAT_POS;
        end
        m = (q << sh) + ((r << sh) / den);
        if (neg)
        begin
            if (m > 64'h8000_0000)
            begin
                sat = 1;
                m   = 64'h8000_0000;
            end
            return -m[31:0];
        end
        if (m > 64'h7fff_ffff)
        begin
            sat = 1;
            m   = 64'h7fff_ffff;
        end
        return m[31:0];
    endfunction

    function automatic solution_t solve_quadratic(coef_t k);
        solution_t          o;
        longint             a;
        longint             b;
        longint             c;
        longint             d;
        longint             nb;
        longint             n1;
        longint             n2;
        logic [63:0]        ua;
        logic [63:0]        dmag;
        logic [63:0]        s;
        bit                 sat;
        a   = k.a;
        b   = k.b;
        c   = k.c;
        sat = 0;
        o   = '0;
        if (a == 0)
        begin
            o.kind = qrs_pkg::KIND_DEGENERATE;
            return o;
        end
        d    = b * b - 4 * a * c;
        ua   = (a < 0) ? -a : a;
        dmag = (d < 0) ? -d : d;
        o.vx = scaled_div((b < 0) == (a < 0), (b < 0) ? -b : b, 2 * ua, FB, sat);
        o.vy = scaled_div((d > 0 && a > 0) || (d < 0 && a < 0), dmag, 4 * ua, FB, sat);
        if (d > 0)
        begin
            o.kind = qrs_pkg::KIND_DISTINCT;
            s    = root_scaled(dmag);
            nb   = -b * (longint'(1) << FB);
            n1   = nb + longint'(s);
            n2   = nb - longint'(s);
            o.r1 = scaled_div((n1 < 0) != (a < 0), (n1 < 0) ? -n1 : n1, 2 * ua, 0, sat);
            o.r2 = scaled_div((n2 < 0) != (a < 0), (n2 < 0) ? -n2 : n2, 2 * ua, 0, sat);
        end
        else if (d == 0)
        begin
            o.kind = qrs_pkg::KIND_DOUBLE;
            o.r1   = o.vx;
            o.r2   = o.vx;
        end
        else
        begin
            o.kind = qrs_pkg::KIND_COMPLEX;
            s    = root_scaled(dmag);
            o.r1 = o.vx;
            o.r2 = scaled_div(a < 0, s, 2 * ua, 0, sat);
        end
        o.sat = sat;
        return o;
    endfunction

    function automatic logic [CB-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return CB'($urandom_range(0, 6) - 3);
            3, 4:    return CB'($urandom_range(0, 64) - 32);
            default: return CB'($urandom());
        endcase
    endfunction

    task automatic add_set(int a, int b, int c);
        coef_t k;
        k.a = CB'(a);
        k.b = CB'(b);
        k.c = CB'(c);
        coef_queue.push_back(k);
    endtask

    task automatic wait_drained();
        while (coef_queue.size() != 0 || req.valid)
            @(posedge clk);
        while (solution_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input acceptance as seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= req.valid && req.ready;
    end

    // driver: offers the head of the pending queue, at random gaps
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.coef_a <= '0;
            req.coef_b <= '0;
            req.coef_c <= '0;
        end
        else if (!req.valid || in_fire)
        begin
            if (coef_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
            begin
                coef_t k;
                k = coef_queue.pop_front();
                req.valid  <= 1'b1;
                req.coef_a <= k.a;
                req.coef_b <= k.b;
                req.coef_c <= k.c;
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off_req && !hold_off_done)
        begin
            rsp.ready       <= 1'b0;
            hold_off_cycles <= 300;
            hold_off_done   <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            rsp.ready       <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            rsp.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // monitor: prediction on accepted inputs, comparison on accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                solution_queue.push_back(solve_quadratic({req.coef_a, req.coef_b, req.coef_c}));
            if (rsp.valid && rsp.ready)
            begin
                if (solution_queue.size() == 0)
                begin
                    $error("unexpected result item");
                    errors++;
                end
                else
                begin
                    solution_t e;
                    e = solution_queue.pop_front();
                    if (rsp.root_kind !== e.kind)
                    begin
                        $error("root_kind expected %0d actual %0d", e.kind, rsp.root_kind);
                        errors++;
                    end
                    if (rsp.root_one !== e.r1)
                    begin
                        $error("root_one expected %0d actual %0d", e.r1, rsp.root_one);
                        errors++;
                    end
                    if (rsp.root_two !== e.r2)
                    begin
                        $error("root_two expected %0d actual %0d", e.r2, rsp.root_two);
                        errors++;
                    end
                    if (rsp.vertex_x !== e.vx)
                    begin
                        $error("vertex_x expected %0d actual %0d", e.vx, rsp.vertex_x);
                        errors++;
                    end
                    if (rsp.vertex_y !== e.vy)
                    begin
                        $error("vertex_y expected %0d actual %0d", e.vy, rsp.vertex_y);
                        errors++;
                    end
                    if (rsp.saturated !== e.sat)
                    begin
                        $error("saturated expected %0d actual %0d", e.sat, rsp.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n           = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_req    = 0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;

        // directed: degenerate, double, complex, distinct, extremes, clipping
        add_set(0, 5, 7);
        add_set(0, -32768, 32767);
        add_set(1, -2, 1);
        add_set(1, 0, 1);
        add_set(-1, 0, 1);
        add_set(1, -3, 2);
        add_set(-1, 3, -2);
        add_set(1, 0, -32768);
        add_set(1, 32767, 0);
        add_set(1, -32768, -32768);
        add_set(-32768, -32768, -32768);
        add_set(32767, 32767, 32767);
        add_set(-32768, 32767, 32767);
        add_set(32767, -32768, -32768);
        add_set(1, -32768, 32767);
        add_set(-1, 32767, -32768);
        add_set(2, 4, 2);
        add_set(3, 1, 5);
        add_set(-7, -1, 0);
        add_set(1, 1, 1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 8 : 47) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 8 : 47) : 0;
            if (phase == 2)
                hold_off_req = 1;
            for (int n = 0; n < 430; n++)
            begin
                coef_t k;
                k.a = pick_coef();
                k.b = pick_coef();
                k.c = pick_coef();
                // steer some sets onto the double root
                if ($urandom_range(0, 15) == 0)
                begin
                    k.a = CB'($urandom_range(1, 100));
                    k.b = CB'(2 * k.a * (int'($urandom_range(0, 20)) - 10));
                    k.c = CB'(k.b * k.b / (4 * k.a));
                end
                coef_queue.push_back(k);
            end
            wait_drained();
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
